// ===== rtl/core/dptm_pkg.sv =====
package dptm_pkg;

	localparam int unsigned CntW = 16;
	localparam int unsigned SmpW = 16;
	localparam int unsigned AddrW = 4;
	localparam int unsigned DataW = 32;

	localparam logic [CntW-1:0] DebounceRst = 16'd50;
	localparam logic [CntW-1:0] OnDelayRst = 16'd100;
	localparam logic [CntW-1:0] AdcDelayRst = 16'd50;
	localparam logic [CntW-1:0] ThresholdRst = 16'd52428;

	typedef enum logic [1:0] {
		REG_DEBOUNCE  = 2'd0,
		REG_ON_DELAY  = 2'd1,
		REG_ADC_DELAY = 2'd2,
		REG_THRESHOLD = 2'd3
	} reg_idx_t;

	typedef enum logic {
		FUNC_TICK   = 1'b0,
		FUNC_SAMPLE = 1'b1
	} func_t;

	typedef struct packed {
		logic [CntW-1:0] debounce_count;
		logic [CntW-1:0] on_delay;
		logic [CntW-1:0] adc_delay;
		logic [SmpW-1:0] overload_threshold;
	} cfg_t;

	typedef struct packed {
		logic [SmpW-1:0] vdd_sample;
		logic            adc_busy;
		logic            button_level;
		func_t           func;
	} item_t;

	// power_state sits in bit 0
	typedef struct packed {
		logic off_notify;
		logic ready_notify;
		logic start_conversion;
		logic supply_off_now;
		logic supply_off_deferred;
		logic supply_enable_now;
		logic power_state;
	} result_t;

endpackage

// ===== rtl/core/dptm_cfg_regs.sv =====
module dptm_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dptm_pkg::AddrW-1:0]   paddr,
	input  logic [dptm_pkg::DataW-1:0]   pwdata,
	output logic [dptm_pkg::DataW-1:0]   prdata,
	output logic                         pready,
	output dptm_pkg::cfg_t               cfg
);
	import dptm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count     <= DebounceRst;
			cfg_q.on_delay           <= OnDelayRst;
			cfg_q.adc_delay          <= AdcDelayRst;
			cfg_q.overload_threshold <= ThresholdRst;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			unique case (idx)
				REG_DEBOUNCE:  cfg_q.debounce_count     <= pwdata[CntW-1:0];
				REG_ON_DELAY:  cfg_q.on_delay           <= pwdata[CntW-1:0];
				REG_ADC_DELAY: cfg_q.adc_delay          <= pwdata[CntW-1:0];
				REG_THRESHOLD: cfg_q.overload_threshold <= pwdata[SmpW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DEBOUNCE:  prdata = {{(DataW-CntW){1'b0}}, cfg_q.debounce_count};
			REG_ON_DELAY:  prdata = {{(DataW-CntW){1'b0}}, cfg_q.on_delay};
			REG_ADC_DELAY: prdata = {{(DataW-CntW){1'b0}}, cfg_q.adc_delay};
			REG_THRESHOLD: prdata = {{(DataW-SmpW){1'b0}}, cfg_q.overload_threshold};
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/dptm_core.sv =====
module dptm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  dptm_pkg::item_t    item,
	input  dptm_pkg::cfg_t     cfg,
	output dptm_pkg::result_t  res
);
	import dptm_pkg::*;

	logic            last_level_q;
	logic [CntW-1:0] stable_ticks_q;
	logic [CntW-1:0] recovery_ticks_q;
	logic            powered_q;

	logic            last_level_d;
	logic [CntW-1:0] stable_ticks_d;
	logic [CntW-1:0] recovery_ticks_d;
	logic            powered_d;

	logic [CntW-1:0] rec_dec;
	logic [CntW-1:0] limit;
	logic [CntW-1:0] stable_inc;
	logic [CntW-1:0] gap;
	logic            toggle;

	always_comb begin
		last_level_d     = last_level_q;
		stable_ticks_d   = stable_ticks_q;
		recovery_ticks_d = recovery_ticks_q;
		powered_d        = powered_q;
		res              = '0;

		rec_dec    = (recovery_ticks_q != '0) ? recovery_ticks_q - 1'b1 : recovery_ticks_q;
		limit      = (cfg.debounce_count == '1) ? cfg.debounce_count
			: cfg.debounce_count + 1'b1;
		stable_inc = (stable_ticks_q < limit) ? stable_ticks_q + 1'b1 : stable_ticks_q;
		gap        = (cfg.on_delay > cfg.adc_delay) ? cfg.on_delay - cfg.adc_delay : '0;
		toggle     = (stable_inc == cfg.debounce_count) && item.button_level;

		if (item.func == FUNC_TICK) begin
			recovery_ticks_d = rec_dec;
			if (item.button_level != last_level_q) begin
				stable_ticks_d = '0;
				last_level_d   = item.button_level;
			end else begin
				stable_ticks_d = stable_inc;
				if (toggle) begin
					powered_d = !powered_q;
					if (!powered_q) begin
						res.supply_enable_now = 1'b1;
						recovery_ticks_d      = cfg.on_delay;
					end else begin
						res.off_notify          = 1'b1;
						res.supply_off_deferred = 1'b1;
					end
				end
				res.start_conversion = (recovery_ticks_d <= gap) && powered_d && !item.adc_busy;
				res.ready_notify     = (recovery_ticks_d == CntW'(1));
			end
		end else begin
			if (powered_q && item.vdd_sample < cfg.overload_threshold) begin
				res.off_notify     = 1'b1;
				res.supply_off_now = 1'b1;
				powered_d          = 1'b0;
			end
		end
		res.power_state = powered_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q     <= 1'b0;
			stable_ticks_q   <= '0;
			recovery_ticks_q <= '0;
			powered_q        <= 1'b0;
		end else if (step_en) begin
			last_level_q     <= last_level_d;
			stable_ticks_q   <= stable_ticks_d;
			recovery_ticks_q <= recovery_ticks_d;
			powered_q        <= powered_d;
		end
	end

endmodule

// ===== rtl/core/debounced_power_toggle_monitor.sv =====
// Push-button power switch with supply overload cut. Each input beat is a poll tick
// (tuser 0: button level and converter busy flag) or a supply sample (tuser 1), and
// each beat yields exactly one result beat of event flags. A beat is registered on
// entry, evaluated combinationally against the switch state and held in an output
// register, so the block takes one beat per cycle while the result side accepts;
// the output register is the only thing that stalls the input when the result
// side holds off. Registers: 0x0 debounce count, 0x4 on delay, 0x8 adc delay,
// 0xC overload threshold, all 16 bits; write them only while the block is idle.
module debounced_power_toggle_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dptm_pkg::AddrW-1:0] paddr,
	input  logic [dptm_pkg::DataW-1:0] pwdata,
	output logic [dptm_pkg::DataW-1:0] prdata,
	output logic                       pready,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [23:0]                s_tdata,  // button_level, adc_busy, vdd_sample[15:0]
	input  logic                       s_tuser,  // func
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata   // power_state, supply_enable_now,
	                                             // supply_off_deferred, supply_off_now,
	                                             // start_conversion, ready_notify,
	                                             // off_notify
);
	import dptm_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2};

	dptm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dptm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (valid_s1 && advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func         <= func_t'(s_tuser);
			item_s1.button_level <= s_tdata[0];
			item_s1.adc_busy     <= s_tdata[1];
			item_s1.vdd_sample   <= s_tdata[SmpW+1:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== sim/tb_debounced_power_toggle_monitor.sv =====
module tb_debounced_power_toggle_monitor;

	import dptm_pkg::*;

	localparam int IdleLimit = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic             pready;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	always #4 clk = ~clk;

	debounced_power_toggle_monitor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// switch state as the block should hold it
	cfg_t            cfg = '{DebounceRst, OnDelayRst, AdcDelayRst, ThresholdRst};
	logic            last_lvl = 1'b0;
	logic [CntW-1:0] stable_cnt = '0;
	logic [CntW-1:0] rec_ticks = '0;
	logic            powered = 1'b0;

	item_t   pending_inputs[$];
	result_t flags_due[$];

	int queued = 0;
	int fails = 0;
	int beats_out = 0;
	int n_ticks = 0, n_samples = 0;
	int n_on = 0, n_defer = 0, n_cut = 0, n_conv = 0, n_ready = 0;

	logic     hold_send = 1'b0;
	logic     send_gaps = 1'b0;
	logic [1:0] rdy_mode = 2'd0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       rdy_cnt = 0;
	int       idle_cycles = 0;

	string flag_name[7] = '{"power_state", "supply_enable_now", "supply_off_deferred",
		"supply_off_now", "start_conversion", "ready_notify", "off_notify"};

	function automatic result_t switch_step(item_t it);
		result_t     r;
		logic [16:0] lim;
		logic [15:0] gap;
		r = '0;
		if (it.func == FUNC_TICK) begin
			if (rec_ticks != 0)
				rec_ticks = rec_ticks - 1'b1;
			if (it.button_level != last_lvl) begin
				stable_cnt = '0;
				last_lvl = it.button_level;
			end else begin
				lim = {1'b0, cfg.debounce_count} + 17'd1;
				if (lim > 17'hFFFF)
					lim = 17'hFFFF;
				if ({1'b0, stable_cnt} < lim)
					stable_cnt = stable_cnt + 1'b1;
				if (stable_cnt == cfg.debounce_count && it.button_level) begin
					powered = !powered;
					if (powered) begin
						r.supply_enable_now = 1'b1;
						rec_ticks = cfg.on_delay;
					end else begin
						r.off_notify = 1'b1;
						r.supply_off_deferred = 1'b1;
					end
				end
				gap = (cfg.on_delay > cfg.adc_delay) ? cfg.on_delay - cfg.adc_delay : 16'd0;
				if (rec_ticks <= gap && powered && !it.adc_busy)
					r.start_conversion = 1'b1;
				if (rec_ticks == 16'd1)
					r.ready_notify = 1'b1;
			end
		end else if (powered && it.vdd_sample < cfg.overload_threshold) begin
			r.off_notify = 1'b1;
			r.supply_off_now = 1'b1;
			powered = 1'b0;
		end
		r.power_state = powered;
		return r;
	endfunction

	function automatic void add_tick(logic lvl, logic busy);
		item_t it;
		it.func = FUNC_TICK;
		it.button_level = lvl;
		it.adc_busy = busy;
		it.vdd_sample = 16'($urandom);
		pending_inputs.push_back(it);
		queued++;
	endfunction

	function automatic void add_sample(logic [15:0] v);
		item_t it;
		it.func = FUNC_SAMPLE;
		it.button_level = 1'($urandom_range(0, 1));
		it.adc_busy = 1'($urandom_range(0, 1));
		it.vdd_sample = v;
		pending_inputs.push_back(it);
		queued++;
	endfunction

	function automatic logic [15:0] pick_vdd();
		case ($urandom_range(0, 5))
			0: return cfg.overload_threshold;
			1: return cfg.overload_threshold - 16'd1;
			2: return cfg.overload_threshold + 16'd1;
			3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// presses of about the debounce count where it is small, with bounce and stray samples mixed in
	function automatic void fill_random(int n);
		int goal, len, k;
		goal = queued + n;
		while (queued < goal) begin
			k = $urandom_range(0, 9);
			if (k <= 6) begin
				if (cfg.debounce_count != 0 && cfg.debounce_count <= 60)
					len = cfg.debounce_count + $urandom_range(0, 3);
				else
					len = $urandom_range(1, 12);
				repeat (len) begin
					if ($urandom_range(0, 4) == 0)
						add_sample(pick_vdd());
					add_tick(1'b1, $urandom_range(0, 3) == 0);
				end
				repeat ($urandom_range(1, 6))
					add_tick(1'b0, $urandom_range(0, 3) == 0);
			end else if (k <= 8) begin
				repeat ($urandom_range(1, 4))
					add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 3))
					add_sample(pick_vdd());
			end
		end
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DEBOUNCE:  cfg.debounce_count = val;
			REG_ON_DELAY:  cfg.on_delay = val;
			REG_ADC_DELAY: cfg.adc_delay = val;
			REG_THRESHOLD: cfg.overload_threshold = val;
		endcase
	endtask

	task automatic drain();
		while (pending_inputs.size() != 0 || s_tvalid || flags_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] db, logic [15:0] ond, logic [15:0] adcd,
			logic [15:0] thr, int n, logic gaps, logic [1:0] rmode);
		drain();
		write_reg(REG_DEBOUNCE, db);
		write_reg(REG_ON_DELAY, ond);
		write_reg(REG_ADC_DELAY, adcd);
		write_reg(REG_THRESHOLD, thr);
		send_gaps <= gaps;
		rdy_mode <= rmode;
		fill_random(n);
	endtask

	// sender
	always @(posedge clk) begin
		result_t due;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (s_tvalid) begin
				if (pending_inputs[0].func == FUNC_TICK)
					n_ticks++;
				else
					n_samples++;
				due = switch_step(pending_inputs.pop_front());
				flags_due.push_back(due);
				n_on += due.supply_enable_now;
				n_defer += due.supply_off_deferred;
				n_cut += due.supply_off_now;
				n_conv += due.start_conversion;
				n_ready += due.ready_notify;
			end
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (hold_send || pending_inputs.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {6'd0, pending_inputs[0].vdd_sample, pending_inputs[0].adc_busy,
					pending_inputs[0].button_level};
				s_tuser <= pending_inputs[0].func;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 20);
					gap_left = send_gaps ? $urandom_range(1, 6) : 0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			rdy_cnt++;
			case (rdy_mode)
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= $urandom_range(0, 2) != 0;
				2'd2: m_tready <= $urandom_range(0, 3) == 0;
				default: m_tready <= (rdy_cnt % 8) > 2;
			endcase
			if (m_tvalid && m_tready) begin
				beats_out++;
				got = result_t'(m_tdata[6:0]);
				if (flags_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("beat %0d: result with nothing expected, got %b",
							beats_out, got);
				end else begin
					want = flags_due.pop_front();
					for (int i = 0; i < 7; i++) begin
						if (got[i] !== want[i]) begin
							fails++;
							if (fails <= 10)
								$display("beat %0d: %s expected %b got %b",
									beats_out, flag_name[i], want[i], got[i]);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles == IdleLimit) begin
					$display("timeout: no beat for %0d cycles", IdleLimit);
					$display("debounced_power_toggle_monitor: mismatch");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// short settle times so each case shows within a few ticks
		write_reg(REG_DEBOUNCE, 16'd2);
		write_reg(REG_ON_DELAY, 16'd6);
		write_reg(REG_ADC_DELAY, 16'd2);
		write_reg(REG_THRESHOLD, 16'h8000);
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b1);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b1);
		add_sample(16'h8000);
		add_sample(16'hFFFF);
		add_sample(16'h7FFF);
		add_sample(16'h0000);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b1);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b1);

		run_phase(DebounceRst, OnDelayRst, AdcDelayRst, ThresholdRst, 130, 1'b1, 2'd1);
		run_phase(16'd1, 16'd1, 16'd0, 16'd0, 100, 1'b0, 2'd0);
		run_phase(16'd3, 16'd6, 16'd65535, 16'd65535, 90, 1'b1, 2'd2);
		run_phase(16'd0, 16'd7, 16'd0, 16'd30000, 50, 1'b1, 2'd3);
		run_phase(16'd4, 16'd65535, 16'd3, 16'd20000, 90, 1'b0, 2'd2);
		run_phase(16'd65535, 16'd10, 16'd10, 16'd1, 30, 1'b1, 2'd0);
		run_phase(16'd2, 16'd8, 16'd3, 16'd40000, 140, 1'b1, 2'd1);

		// hold the sender until the result side has caught up
		while (pending_inputs.size() > 70)
			@(posedge clk);
		hold_send <= 1'b1;
		while (s_tvalid || flags_due.size() != 0)
			@(posedge clk);
		hold_send <= 1'b0;

		drain();
		repeat (6) @(posedge clk);
		if (flags_due.size() != 0) begin
			fails++;
			$display("%0d results never arrived", flags_due.size());
		end
		$display("ran %0d poll ticks and %0d supply samples over eight register settings",
			n_ticks, n_samples);
		$display("saw %0d switch-ons, %0d deferred cuts, %0d overload cuts, %0d conversions, %0d ready",
			n_on, n_defer, n_cut, n_conv, n_ready);
		if (fails == 0)
			$display("debounced_power_toggle_monitor: match");
		else
			$display("debounced_power_toggle_monitor: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/dptm_pkg.sv
rtl/core/dptm_cfg_regs.sv
rtl/core/dptm_core.sv
rtl/core/debounced_power_toggle_monitor.sv
sim/tb_debounced_power_toggle_monitor.sv
